// ===== rtl/vcpsel_pkg.sv =====
package vcpsel_pkg;

    localparam int CODE_W  = 16;
    localparam int COUNT_W = 6;
    localparam int CHAR_W  = 8;

    // Search phase codes for the "60(" opener.
    localparam logic [1:0] PH_SEARCH   = 2'd0;
    localparam logic [1:0] PH_SIX      = 2'd1;
    localparam logic [1:0] PH_SIX_ZERO = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NO_LIST   = 2'd1;
    localparam logic [1:0] ST_FEW_CODES = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_SIX   = 8'h36;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CODE_W-1:0] TOKEN_SAT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         phase;
        logic               prev_hex;
        logic               in_list;
        logic               closed;
        logic               tok_open;
        logic [CODE_W-1:0]  tok_val;
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  first;
        logic               seen;
        logic               taken;
        logic [CODE_W-1:0]  follower;
    } t_parse;

    typedef struct packed {
        logic [COUNT_W-1:0] codes_found;
        logic [1:0]         status;
        logic [CODE_W-1:0]  next_code;
    } t_result;

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/vcpsel_step.sv =====
module vcpsel_step
    import vcpsel_pkg::*;
#(
    parameter int CODE_LIMIT = 32
) (
    input  t_parse            i_cur,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    input  logic [7:0]        i_cur_low,
    output t_parse            o_next,
    output t_result           o_result
);

    localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(CODE_LIMIT);

    logic [4:0]        hex;
    logic              is_hex;
    logic [CODE_W-1:0] new_tok;
    logic [CODE_W-1:0] fin_val;
    logic              fin;
    t_parse            n;

    assign hex    = hex_decode(i_char);
    assign is_hex = hex[4];

    // Shifting in a digit overflows exactly when the top nibble is nonzero.
    assign new_tok = !i_cur.tok_open ? {12'd0, hex[3:0]} :
                     (i_cur.tok_val[15:12] != 4'd0) ? TOKEN_SAT :
                     {i_cur.tok_val[11:0], hex[3:0]};

    always_comb begin
        n       = i_cur;
        fin     = 1'b0;
        fin_val = i_cur.tok_val;

        if (i_cur.in_list) begin
            if (!i_cur.closed) begin
                if (is_hex) begin
                    n.tok_val  = new_tok;
                    n.tok_open = 1'b1;
                end else if (i_char == CHAR_SPACE) begin
                    fin = i_cur.tok_open;
                end else begin
                    fin      = i_cur.tok_open;
                    n.closed = 1'b1;
                end
            end
        end else begin
            if (i_cur.phase == PH_SIX_ZERO && i_char == CHAR_OPEN) begin
                n.in_list = 1'b1;
                n.phase   = PH_SEARCH;
            end else if (i_cur.phase == PH_SIX && i_char == CHAR_ZERO) begin
                n.phase = PH_SIX_ZERO;
            end else if (i_char == CHAR_SIX && !i_cur.prev_hex) begin
                n.phase = PH_SIX;
            end else begin
                n.phase = PH_SEARCH;
            end
        end
        n.prev_hex = is_hex;

        // A token still open at the end of the string is completed here.
        if (i_last && n.in_list && !n.closed && n.tok_open) begin
            fin     = 1'b1;
            fin_val = n.tok_val;
        end

        if (fin) begin
            n.tok_open = 1'b0;
            n.tok_val  = '0;
            if (n.count == '0) begin
                n.first = fin_val;
            end
            if (n.seen && !n.taken) begin
                n.follower = fin_val;
                n.taken    = 1'b1;
            end
            if (!n.seen && fin_val == {8'd0, i_cur_low}) begin
                n.seen = 1'b1;
            end
            n.count = n.count + 1'b1;
            if (n.count >= MaxCount) begin
                n.closed = 1'b1;
            end
        end
    end

    always_comb begin
        o_next               = n;
        o_result.next_code   = '0;
        o_result.codes_found = n.in_list ? n.count : '0;
        if (!n.in_list) begin
            o_result.status = ST_NO_LIST;
        end else if (n.count < COUNT_W'(2)) begin
            o_result.status = ST_FEW_CODES;
        end else begin
            o_result.status    = ST_FOUND;
            o_result.next_code = (n.seen && n.taken) ? n.follower : n.first;
        end
    end

endmodule

// ===== rtl/vcp_input_list_next_selector.sv =====
// Takes a capabilities string one character per request on the slave stream
// (tlast on the final character) and returns one result per string: the input
// code that follows the low byte of current_input in the "60(...)" list, wrapping
// to the first code, or the first code if that value is absent. One character is
// taken every clock cycle; each is parsed by a single combinational step into the
// parser state registers, and the result is captured in an output register as
// the final character is taken. While a result waits there unread, the slave
// stream is held off. current_input sits at APB byte address 0; the user must
// write it only between strings, which the block itself does not enforce.
module vcp_input_list_next_selector
    import vcpsel_pkg::*;
#(
    parameter int CODE_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] next_code, [21:16] codes_found, zero fill
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_parse            r_state;
    t_parse            n_state;
    t_result           step_result;
    t_result           r_result;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_cur_input;
    logic              accept;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {16'd0, r_cur_input} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_input <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_cur_input <= pwdata[CODE_W-1:0];
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    vcpsel_step #(
        .CODE_LIMIT (CODE_LIMIT)
    ) u_step (
        .i_cur     (r_state),
        .i_char    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_cur_low (r_cur_input[7:0]),
        .o_next    (n_state),
        .o_result  (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                // The parser starts over after the final character.
                r_state <= s_axis_tlast ? '0 : n_state;
            end
            if (accept && s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'd0, r_result.codes_found, r_result.next_code};
    assign m_axis_tuser  = r_result.status;

endmodule

// ===== tb/vcp_input_list_next_selector_test.sv =====
module vcp_input_list_next_selector_test;
    import vcpsel_pkg::*;

    localparam int CODE_LIMIT = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] ADDR_CURRENT_INPUT = 3'd0;

    typedef struct {
        logic [7:0] ch;
        logic       is_end;
    } t_char_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;      // [7:0] char_byte
    logic        s_axis_tlast = 1'b0;       // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;              // [15:0] next_code, [21:16] codes_found, zero fill
    logic [1:0]  m_axis_tuser;              // [1:0] status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    vcp_input_list_next_selector #(.CODE_LIMIT(CODE_LIMIT)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Character requests waiting for the driver, and selections still owed by the block.
    t_char_req   char_q[$];
    t_result     expected_selections[$];
    logic [7:0]  draft[$];

    // Mirror of the selector's register and parse state.
    logic [15:0] sel_input = 16'd0;
    logic [1:0]  scan_phase;
    logic        after_hex;
    logic        list_open;
    logic        list_done;
    logic        digit_run;
    logic [15:0] run_value;
    logic [5:0]  list_len;
    logic [15:0] head_code;
    logic        cur_hit;
    logic        succ_ready;
    logic [15:0] succ_code;

    int          errors = 0;
    int          chars_taken = 0;
    int          chars_offered = 0;
    int          chars_queued = 0;
    int          strings_queued = 0;
    int          selections_checked = 0;
    int          settings_used = 0;
    int          idle_cycles = 0;
    int          char_gap = 0;
    int          ready_hold = 0;
    bit          stall_mode = 1'b0;

    logic [7:0]  stoppers[5] = '{8'h09, 8'h2D, 8'h78, 8'h00, 8'h47};

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!stall_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic restart_parse();
        scan_phase = PH_SEARCH;
        after_hex  = 1'b0;
        list_open  = 1'b0;
        list_done  = 1'b0;
        digit_run  = 1'b0;
        run_value  = 16'd0;
        list_len   = 6'd0;
        head_code  = 16'd0;
        cur_hit    = 1'b0;
        succ_ready = 1'b0;
        succ_code  = 16'd0;
    endtask

    task automatic close_token();
        logic [15:0] v;
        v = run_value;
        digit_run = 1'b0;
        run_value = 16'd0;
        if (list_len == 0) head_code = v;
        if (cur_hit && !succ_ready) begin
            succ_code  = v;
            succ_ready = 1'b1;
        end
        // Only the low byte of current_input takes part in the match.
        if (!cur_hit && v == {8'h00, sel_input[7:0]}) cur_hit = 1'b1;
        list_len++;
        if (list_len >= CODE_LIMIT) list_done = 1'b1;
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic is_end);
        int      d;
        int      v;
        t_result r;
        d = nibble_of(ch);
        if (list_open) begin
            if (!list_done) begin
                if (d >= 0) begin
                    v = digit_run ? int'(run_value) * 16 + d : d;
                    run_value = (v > 32'hFFFF) ? TOKEN_SAT : v[15:0];
                    digit_run = 1'b1;
                end else if (ch == CHAR_SPACE) begin
                    if (digit_run) close_token();
                end else begin
                    if (digit_run) close_token();
                    list_done = 1'b1;
                end
            end
        end else begin
            if (scan_phase == PH_SIX_ZERO && ch == CHAR_OPEN) begin
                list_open  = 1'b1;
                scan_phase = PH_SEARCH;
            end else if (scan_phase == PH_SIX && ch == CHAR_ZERO) begin
                scan_phase = PH_SIX_ZERO;
            end else begin
                scan_phase = (ch == CHAR_SIX && !after_hex) ? PH_SIX : PH_SEARCH;
            end
        end
        after_hex = (d >= 0);
        if (is_end) begin
            if (list_open && !list_done && digit_run) close_token();
            r.next_code   = 16'd0;
            r.codes_found = list_open ? list_len : 6'd0;
            if (!list_open) begin
                r.status = ST_NO_LIST;
            end else if (list_len < 2) begin
                r.status = ST_FEW_CODES;
            end else begin
                r.status    = ST_FOUND;
                r.next_code = (cur_hit && succ_ready) ? succ_code : head_code;
            end
            expected_selections.push_back(r);
            restart_parse();
        end
    endtask

    // Character driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || chars_taken == chars_offered) begin
            if (s_axis_tvalid) char_gap = pick_gap();
            if (char_gap > 0) begin
                char_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (char_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= char_q[0].ch;
                s_axis_tlast  <= char_q[0].is_end;
                chars_offered++;
            end
        end
    end

    // Result backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
        end
    end

    // Monitor, predictor and watchdog.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            restart_parse();
            sel_input = 16'd0;
        end else begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                parse_char(s_axis_tdata, s_axis_tlast);
                void'(char_q.pop_front());
                chars_taken++;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                selections_checked++;
                if (expected_selections.size() == 0) begin
                    $error("unexpected result: next_code %h status %0d codes_found %0d",
                           m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[21:16]);
                    errors++;
                end else begin
                    want = expected_selections.pop_front();
                    if (m_axis_tdata[15:0] !== want.next_code) begin
                        $error("next_code: expected %h, got %h",
                               want.next_code, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[21:16] !== want.codes_found) begin
                        $error("codes_found: expected %0d, got %0d",
                               want.codes_found, m_axis_tdata[21:16]);
                        errors++;
                    end
                    if (m_axis_tdata[23:22] !== 2'b00) begin
                        $error("tdata fill: expected 0, got %b", m_axis_tdata[23:22]);
                        errors++;
                    end
                end
            end
            if (psel && penable && pready) begin
                idle_cycles = 0;
                if (pwrite) begin
                    sel_input = pwdata[15:0];
                end else if (prdata[15:0] !== sel_input) begin
                    $error("current_input readback: expected %h, got %h",
                           sel_input, prdata[15:0]);
                    errors++;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic draft_text(input string s);
        for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    endtask

    // Moves the drafted string into the request queue, tlast on its final character.
    task automatic commit_draft();
        t_char_req req;
        for (int i = 0; i < draft.size(); i++) begin
            req.ch     = draft[i];
            req.is_end = (i == draft.size() - 1);
            char_q.push_back(req);
        end
        chars_queued += draft.size();
        strings_queued++;
        draft.delete();
    endtask

    task automatic settle();
        while (char_q.size() != 0 || expected_selections.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_current_input(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CURRENT_INPUT;
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic draft_random_string();
        string pool;
        string tok;
        int    n;
        int    pick;
        pool = "VCP(mcs )6A0b-";
        if ($urandom_range(0, 9) < 3) begin
            n = $urandom_range(1, 8);
            repeat (n) draft.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) draft.push_back(pool[$urandom_range(0, pool.len() - 1)]);
        case ($urandom_range(0, 11))
            0:       draft_text("6 0(");
            1:       draft_text("600(");
            2:       draft_text("6(");
            default: draft_text("60(");
        endcase
        if ($urandom_range(0, 3) == 0) draft_text(" ");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 11);
            if (pick < 4) tok = $sformatf("%02x", sel_input[7:0]);
            else if (pick == 4) tok = $sformatf("%05x", $urandom_range(0, 20'hFFFFF));
            else if (pick == 5) tok = $sformatf("%0x", $urandom_range(0, 15));
            else if (pick == 6) tok = $sformatf("%04x", $urandom_range(0, 255));
            else tok = $sformatf("%02x", $urandom_range(0, 255));
            if ($urandom_range(0, 1)) tok = tok.toupper();
            draft_text(tok);
            if (i < n - 1) draft_text(($urandom_range(0, 4) == 0) ? "  " : " ");
        end
        case ($urandom_range(0, 3))
            0: begin
                draft_text(")");
                if ($urandom_range(0, 1)) draft_text(" 60(1 2)");
            end
            1: ;
            2: draft_text(")");
            default: draft.push_back(stoppers[$urandom_range(0, 4)]);
        endcase
    endtask

    initial begin
        logic [15:0] settings[4];
        int          phase_chars;
        int          phase_strings;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_current_input(16'h0011);
        stall_mode = 1'b1;
        // Wrap from the last code to the first, closed by a parenthesis.
        draft_text("60(F 11)");
        commit_draft();
        // A hex digit before the six hides the opener.
        draft_text("a60(1");
        commit_draft();
        // Saturated first token, current input found last with a token open at the end.
        draft_text("60(12345 11");
        commit_draft();
        // A tab ends the list after one code.
        draft_text("60(5\t6");
        commit_draft();
        // Zero byte as plain text, then a repeated current input.
        draft.push_back(8'h00);
        draft_text("60(7 11 7 11");
        commit_draft();
        draft.push_back(8'hFF);
        commit_draft();
        settle();

        settings[0] = 16'h0000;
        settings[1] = 16'hFFFF;
        settings[2] = 16'($urandom);
        settings[3] = 16'($urandom);
        for (int p = 0; p < 4; p++) begin
            set_current_input(settings[p]);
            stall_mode = (p != 2);
            phase_chars   = chars_queued;
            phase_strings = strings_queued;
            while (chars_queued - phase_chars < 85 || strings_queued - phase_strings < 4) begin
                draft_random_string();
                commit_draft();
            end
            // The sender holds off here until every selection has come back.
            settle();
        end

        settle();
        $display("Drove %0d characters in %0d strings under %0d current_input settings.",
                 chars_queued, strings_queued, settings_used);
        $display("Checked %0d selections, covering missing lists, short lists and full lists.",
                 selections_checked);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
